/* rtl/spsi_pkg.sv */
// ----------------------------------------------------------------------------
// spsi_pkg
// Shared types and constants of the servo position step interpolator.
// ----------------------------------------------------------------------------
package spsi_pkg;

  localparam int unsigned STEP_W     = 32;
  localparam int unsigned CPS_W      = 17;
  localparam int unsigned UPR_W      = 31;
  localparam int unsigned FFMAX_W    = 31;
  localparam int unsigned MAXSTEP_W  = 31;
  localparam int unsigned DB_W       = 16;
  localparam int unsigned SETTLE_W   = 8;
  localparam int unsigned MASK_W     = 5;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROD_W     = STEP_W + CPS_W;
  localparam int unsigned FRAC_BITS  = 20;
  localparam int unsigned NUM_W      = PROD_W + FRAC_BITS;
  localparam int unsigned DCNT_W     = $clog2(NUM_W);
  localparam int unsigned QKEEP_W    = 33;

  localparam logic [MAXSTEP_W-1:0] MAX_STEP_RST = MAXSTEP_W'(5000);
  localparam logic [DB_W-1:0]      DEADBAND_RST = DB_W'(1);
  localparam logic [SETTLE_W-1:0]  SETTLE_RST   = SETTLE_W'(3);
  localparam logic [MASK_W-1:0]    FF_MASK_RST  = MASK_W'(3);
  localparam logic [UPR_W-1:0]     UPR_RST      = UPR_W'(50000);
  localparam logic [CPS_W-1:0]     CPS_RST      = CPS_W'(500);
  localparam logic [FFMAX_W-1:0]   FF_MAX_RST   = FFMAX_W'(500000);

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ABS_HOST = 3'd1,
    OP_ABS_RAW  = 3'd2,
    OP_REL      = 3'd3,
    OP_CONT     = 3'd4,
    OP_STOP     = 3'd5,
    OP_ZERO     = 3'd6,
    OP_RESYNC   = 3'd7
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_STEP    = 4'd0,
    CFG_DEADBAND    = 4'd1,
    CFG_SETTLE      = 4'd2,
    CFG_FF_MASK     = 4'd3,
    CFG_UPR         = 4'd4,
    CFG_CPS         = 4'd5,
    CFG_FF_MAX      = 4'd6,
    CFG_HOST_COORDS = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]         axis;
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic signed [31:0] fb_pos;
  } in_t;

  typedef struct packed {
    logic signed [31:0] target_pos;
    logic signed [31:0] vel_ffwd;
    logic signed [31:0] motion_step;
    logic               seeking;
  } out_t;

  typedef struct packed {
    logic [CPS_W-1:0]   cps;
    logic [UPR_W-1:0]   upr;
    logic [FFMAX_W-1:0] ff_max;
  } ff_cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] mag;
  } ff_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [FFMAX_W-1:0] mag;
  } ff_rsp_t;

endpackage

/* rtl/spsi_ffdiv.sv */
// ----------------------------------------------------------------------------
// spsi_ffdiv
// Feedforward magnitude unit: one multiply, then a bit-serial restoring
// divide of (step * cps) << 20 by units_per_rev, rounded and clamped.
// ----------------------------------------------------------------------------
module spsi_ffdiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spsi_pkg::ff_cfg_t cfg_i,
  input  spsi_pkg::ff_req_t req_i,
  output spsi_pkg::ff_rsp_t rsp_o
);
  import spsi_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_DIV  = 4'b0100,
    D_FIN  = 4'b1000
  } dstate_e;

  dstate_e              state_q, state_d;
  logic [DCNT_W-1:0]    cnt_q;
  logic                 done_q;
  logic [STEP_W-1:0]    mag_q;
  logic [NUM_W-1:0]     num_q;
  logic [UPR_W-1:0]     rem_q;
  logic [QKEEP_W-1:0]   quo_q;
  logic                 big_q;
  logic [FFMAX_W-1:0]   res_q;

  logic [PROD_W-1:0]    prod;
  logic [UPR_W:0]       trial;
  logic [UPR_W:0]       upr_ext;
  logic [UPR_W:0]       trial_sub;
  logic                 fits;
  logic [UPR_W-1:0]     rem_next;
  logic                 round_up;
  logic [QKEEP_W:0]     q_round;
  logic                 sat;

  assign prod      = PROD_W'(mag_q) * PROD_W'(cfg_i.cps);
  assign trial     = {rem_q, num_q[NUM_W-1]};
  assign upr_ext   = {1'b0, cfg_i.upr};
  assign fits      = trial >= upr_ext;
  assign trial_sub = trial - upr_ext;
  assign rem_next  = fits ? trial_sub[UPR_W-1:0] : trial[UPR_W-1:0];
  assign round_up  = {rem_q, 1'b0} >= upr_ext;
  assign q_round   = {1'b0, quo_q} + (QKEEP_W+1)'(round_up);
  assign sat       = big_q || (q_round > (QKEEP_W+1)'(cfg_i.ff_max));

  always_comb begin
    state_d = state_q;
    case (state_q)
      D_IDLE: if (req_i.start) state_d = D_MUL;
      D_MUL:  state_d = D_DIV;
      D_DIV:  if (cnt_q == '0) state_d = D_FIN;
      D_FIN:  state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == D_FIN);
      if (state_q == D_MUL) begin
        cnt_q <= DCNT_W'(NUM_W - 1);
      end else if (state_q == D_DIV) begin
        cnt_q <= cnt_q - DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (req_i.start) mag_q <= req_i.mag;
      end
      D_MUL: begin
        num_q <= {prod, {FRAC_BITS{1'b0}}};
        rem_q <= '0;
        quo_q <= '0;
        big_q <= 1'b0;
      end
      D_DIV: begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        rem_q <= rem_next;
        quo_q <= {quo_q[QKEEP_W-2:0], fits};
        big_q <= big_q | quo_q[QKEEP_W-1];
      end
      D_FIN: begin
        res_q <= sat ? cfg_i.ff_max : q_round[FFMAX_W-1:0];
      end
      default: ;
    endcase
  end

  assign rsp_o.busy = (state_q != D_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.mag  = res_q;

endmodule

/* rtl/servo_position_step_interpolator_core.sv */
// ----------------------------------------------------------------------------
// servo_position_step_interpolator_core
// Per-axis position command generator for cyclic synchronous position drives.
// ----------------------------------------------------------------------------
// Sequence: a request passes S_CALC and S_APPLY to S_POS (an axis out of range goes
//   straight to S_POS); a tick with feedforward also waits in S_FF for the 69-step divider in spsi_ffdiv.
// One request at a time: the input is stalled until the last result leaves S_POS;
//   a finished result waits in S_POS until the output register is free.
// Reset: clears all axis state and loads the register defaults.
module servo_position_step_interpolator_core #(
  parameter int unsigned AXES         = 5,
  parameter int unsigned TRACKER_BITS = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  spsi_pkg::in_t                       in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output spsi_pkg::out_t                      out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spsi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [spsi_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import spsi_pkg::*;

  localparam int unsigned TB = TRACKER_BITS;
  localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_APPLY = 5'b00100,
    S_FF    = 5'b01000,
    S_POS   = 5'b10000
  } state_e;

  // Configuration registers
  logic [MAXSTEP_W-1:0] max_step_q;
  logic [DB_W-1:0]      deadband_q;
  logic [SETTLE_W-1:0]  settle_cyc_q;
  logic [MASK_W-1:0]    ff_mask_q;
  logic [UPR_W-1:0]     upr_q;
  logic [CPS_W-1:0]     cps_q;
  logic [FFMAX_W-1:0]   ff_max_q;
  logic                 host_q;

  // Per-axis state
  logic signed [TB-1:0] trk_q    [AXES];
  logic signed [TB-1:0] goal_q   [AXES];
  logic [AXES-1:0]      active_q;
  logic [7:0]           settle_q [AXES];
  logic signed [31:0]   jog_q    [AXES];
  logic signed [31:0]   zo_q     [AXES];

  state_e               state_q, state_d;
  in_t                  req_q;
  logic [AW-1:0]        idx_q;
  logic                 axis_ok_q;
  logic signed [TB:0]   diff_q;
  logic signed [TB:0]   sum_q;
  logic signed [32:0]   hgoal_q;
  logic signed [31:0]   step_q;
  logic signed [31:0]   ff_q;
  logic                 ff_neg_q;
  logic                 out_valid_q;
  out_t                 out_q;

  ff_cfg_t              ff_cfg;
  ff_req_t              ff_req;
  ff_rsp_t              ff_rsp;

  // Saturate one bit of headroom back into the tracker range.
  function automatic logic signed [TB-1:0] sat_tb(input logic signed [TB:0] v);
    logic signed [TB-1:0] r;
    if (v[TB] != v[TB-1]) begin
      r = v[TB] ? {1'b1, {(TB-1){1'b0}}} : {1'b0, {(TB-1){1'b1}}};
    end else begin
      r = v[TB-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request decode: range check of the axis and index into the state arrays.
  // ---------------------------------------------------------------------------
  logic [AW+2:0] axis_ext;
  logic          axis_ok;
  logic [AW-1:0] axis_idx;

  assign axis_ext = {{AW{1'b0}}, in_i.axis};
  assign axis_ok  = axis_ext < (AW+3)'(AXES);
  assign axis_idx = axis_ok ? axis_ext[AW-1:0] : '0;

  op_e op;
  assign op = op_e'(req_q.operation);

  // Current entry of the addressed axis
  logic signed [TB-1:0] t_cur, g_cur;
  logic                 act_cur;
  logic [7:0]           sc_cur;
  logic signed [31:0]   jog_cur, zo_cur;
  logic signed [TB:0]   t_ext, g_ext, addend;

  assign t_cur   = trk_q[idx_q];
  assign g_cur   = goal_q[idx_q];
  assign act_cur = active_q[idx_q];
  assign sc_cur  = settle_q[idx_q];
  assign jog_cur = jog_q[idx_q];
  assign zo_cur  = zo_q[idx_q];
  assign t_ext   = {t_cur[TB-1], t_cur};
  assign g_ext   = {g_cur[TB-1], g_cur};
  // One adder serves the jog step on a tick and the relative distance.
  assign addend  = (op == OP_TICK) ? {{(TB-31){jog_cur[31]}}, jog_cur}
                                   : {{(TB-31){req_q.value[31]}}, req_q.value};

  // ---------------------------------------------------------------------------
  // Apply step: next entry of the addressed axis and the applied increment.
  // ---------------------------------------------------------------------------
  logic [TB:0]          mag;
  logic                 in_pos, far, dir;
  logic [7:0]           sc_inc;
  logic signed [TB:0]   ms_s, t_up, t_dn, t_far, jdiff;
  logic signed [TB-1:0] trk_seek, jsat;
  logic signed [31:0]   step_seek;

  logic signed [TB-1:0] trk_nx, goal_nx;
  logic                 act_nx;
  logic [7:0]           sc_nx;
  logic signed [31:0]   jog_nx, zo_nx, step_nx;

  assign mag       = diff_q[TB] ? (TB+1)'(-diff_q) : diff_q;
  assign in_pos    = mag < (TB+1)'(deadband_q);
  assign far       = mag > (TB+1)'(max_step_q);
  assign dir       = !diff_q[TB];
  assign sc_inc    = (sc_cur == 8'hFF) ? sc_cur : sc_cur + 8'd1;
  assign ms_s      = $signed({{(TB+1-MAXSTEP_W){1'b0}}, max_step_q});
  assign t_up      = t_ext + ms_s;
  assign t_dn      = t_ext - ms_s;
  assign t_far     = dir ? t_up : t_dn;
  assign trk_seek  = far ? t_far[TB-1:0] : g_cur;
  assign step_seek = far ? (dir ? $signed({1'b0, max_step_q}) : -$signed({1'b0, max_step_q}))
                         : diff_q[31:0];
  assign jsat      = sat_tb(sum_q);
  assign jdiff     = {jsat[TB-1], jsat} - t_ext;

  always_comb begin
    trk_nx  = t_cur;
    goal_nx = g_cur;
    act_nx  = act_cur;
    sc_nx   = sc_cur;
    jog_nx  = jog_cur;
    zo_nx   = zo_cur;
    step_nx = '0;
    case (op)
      OP_TICK: begin
        if (act_cur) begin
          // Seek toward the goal; the last in-position tick still steps.
          sc_nx   = in_pos ? sc_inc : 8'd0;
          trk_nx  = trk_seek;
          step_nx = step_seek;
          if (in_pos && (sc_inc >= settle_cyc_q)) begin
            act_nx = 1'b0;
            sc_nx  = 8'd0;
            jog_nx = '0;
          end
        end else if (jog_cur != '0) begin
          trk_nx  = jsat;
          step_nx = jdiff[31:0];
        end
      end
      OP_ABS_HOST, OP_ABS_RAW: begin
        goal_nx = (op == OP_ABS_HOST) ? {{(TB-33){hgoal_q[32]}}, hgoal_q}
                                      : {{(TB-32){req_q.value[31]}}, req_q.value};
        act_nx  = 1'b1;
        sc_nx   = 8'd0;
        jog_nx  = '0;
      end
      OP_REL: begin
        // A zero distance stops the axis.
        if (req_q.value != '0) begin
          goal_nx = jsat;
          act_nx  = 1'b1;
        end else begin
          act_nx  = 1'b0;
        end
        sc_nx  = 8'd0;
        jog_nx = '0;
      end
      OP_CONT: begin
        act_nx = 1'b0;
        jog_nx = req_q.value;
      end
      OP_STOP: begin
        act_nx = 1'b0;
        sc_nx  = 8'd0;
        jog_nx = '0;
      end
      OP_ZERO: begin
        zo_nx  = -req_q.value;
        act_nx = 1'b0;
        sc_nx  = 8'd0;
        jog_nx = '0;
      end
      OP_RESYNC: begin
        trk_nx = {{(TB-32){req_q.fb_pos[31]}}, req_q.fb_pos};
        act_nx = 1'b0;
        sc_nx  = 8'd0;
        jog_nx = '0;
      end
      default: ;
    endcase
  end

  // Feedforward only on ticks of enabled axes with a nonzero increment and a nonzero upr.
  logic [7:0] mask_ext;
  logic       ff_go;

  assign mask_ext = {{(8-MASK_W){1'b0}}, ff_mask_q};
  assign ff_go    = (op == OP_TICK) && mask_ext[req_q.axis] && (upr_q != '0)
                    && (step_nx != '0);

  assign ff_cfg.cps    = cps_q;
  assign ff_cfg.upr    = upr_q;
  assign ff_cfg.ff_max = ff_max_q;
  assign ff_req.start  = (state_q == S_APPLY) && ff_go;
  assign ff_req.mag    = step_nx[31] ? STEP_W'(0) - STEP_W'(step_nx) : STEP_W'(step_nx);

  spsi_ffdiv u_ffdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (ff_cfg),
    .req_i  (ff_req),
    .rsp_o  (ff_rsp)
  );

  // ---------------------------------------------------------------------------
  // Result: tracker in host or raw coordinates, clamped to 32 bits.
  // ---------------------------------------------------------------------------
  logic signed [TB:0] pos;
  logic signed [31:0] pos32;
  logic               pos_fits;
  logic               out_load;
  out_t               out_d;

  assign pos      = t_ext + (host_q ? {{(TB-31){zo_cur[31]}}, zo_cur} : '0);
  assign pos_fits = (&pos[TB:31]) || !(|pos[TB:31]);
  assign pos32    = pos_fits ? pos[31:0] : (pos[TB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign out_load = (state_q == S_POS) && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_d = '0;
    if (axis_ok_q) begin
      out_d.target_pos  = pos32;
      out_d.vel_ffwd    = ff_q;
      out_d.motion_step = step_q;
      out_d.seeking     = act_cur;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = axis_ok ? S_CALC : S_POS;
      S_CALC:  state_d = S_APPLY;
      S_APPLY: state_d = ff_go ? S_FF : S_POS;
      S_FF:    if (ff_rsp.done) state_d = S_POS;
      S_POS:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && out_stall_i) || out_load;
    end
  end

  // Hold the request and the intermediate sums.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_q     <= in_i;
          idx_q     <= axis_idx;
          axis_ok_q <= axis_ok;
        end
      end
      S_CALC: begin
        diff_q  <= g_ext - t_ext;
        sum_q   <= t_ext + addend;
        hgoal_q <= {req_q.value[31], req_q.value} - {zo_cur[31], zo_cur};
      end
      S_APPLY: begin
        step_q   <= step_nx;
        ff_q     <= '0;
        ff_neg_q <= step_nx[31];
      end
      S_FF: begin
        if (ff_rsp.done) begin
          ff_q <= ff_neg_q ? -$signed({1'b0, ff_rsp.mag}) : $signed({1'b0, ff_rsp.mag});
        end
      end
      default: ;
    endcase
    if (out_load) out_q <= out_d;
  end

  // Update the addressed axis entry once per item with an axis in range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < AXES; i++) begin
        trk_q[i]    <= '0;
        goal_q[i]   <= '0;
        settle_q[i] <= '0;
        jog_q[i]    <= '0;
        zo_q[i]     <= '0;
      end
    end else if (state_q == S_APPLY) begin
      trk_q[idx_q]    <= trk_nx;
      goal_q[idx_q]   <= goal_nx;
      active_q[idx_q] <= act_nx;
      settle_q[idx_q] <= sc_nx;
      jog_q[idx_q]    <= jog_nx;
      zo_q[idx_q]     <= zo_nx;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes; indexes beyond the list are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q   <= MAX_STEP_RST;
      deadband_q   <= DEADBAND_RST;
      settle_cyc_q <= SETTLE_RST;
      ff_mask_q    <= FF_MASK_RST;
      upr_q        <= UPR_RST;
      cps_q        <= CPS_RST;
      ff_max_q     <= FF_MAX_RST;
      host_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_STEP:    max_step_q   <= cfg_data_i[MAXSTEP_W-1:0];
        CFG_DEADBAND:    deadband_q   <= cfg_data_i[DB_W-1:0];
        CFG_SETTLE:      settle_cyc_q <= cfg_data_i[SETTLE_W-1:0];
        CFG_FF_MASK:     ff_mask_q    <= cfg_data_i[MASK_W-1:0];
        CFG_UPR:         upr_q        <= cfg_data_i[UPR_W-1:0];
        CFG_CPS:         cps_q        <= cfg_data_i[CPS_W-1:0];
        CFG_FF_MAX:      ff_max_q     <= cfg_data_i[FFMAX_W-1:0];
        CFG_HOST_COORDS: host_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ff_rsp.busy |-> state_q == S_FF)
    else $error("feedforward divider busy outside its wait state");

  // Non-tick operations move nothing and carry no feedforward.
  a_nontick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (op != OP_TICK) |=>
      (out_o.motion_step == '0) && (out_o.vel_ffwd == '0))
    else $error("non-tick result carries a step or feedforward");

  // One request at a time: an accept closes the input.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

endmodule

/* tb/tb_servo_position_step_interpolator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_position_step_interpolator_core
// Self-checking bench for the servo position step interpolator. A queue of
// motion requests feeds a clocked driver; a clocked monitor predicts every
// setpoint on acceptance and checks each returned setpoint field by field.
// Settings are reloaded between phases while the block is idle, and both
// handshake sides stall at random.
// ----------------------------------------------------------------------------
module tb_servo_position_step_interpolator_core;
  import spsi_pkg::*;

  localparam int unsigned AXES             = 5;
  localparam int unsigned TRACKER_BITS     = 40;
  localparam longint      TRK_HI           = (64'sd1 <<< (TRACKER_BITS - 1)) - 1;
  localparam longint      TRK_LO           = -TRK_HI - 1;
  localparam int unsigned DRAIN_CYCLES     = 100;
  localparam int unsigned LONG_HOLD_AT     = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RUNAWAY_TICKS    = 258;
  localparam int unsigned MAX_PRINTS       = 40;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_i        = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  servo_position_step_interpolator_core #(
    .AXES         (AXES),
    .TRACKER_BITS (TRACKER_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Settings as the block should currently hold them.
  logic [MAXSTEP_W-1:0] set_max_step  = MAX_STEP_RST;
  logic [DB_W-1:0]      set_deadband  = DEADBAND_RST;
  logic [SETTLE_W-1:0]  set_settle    = SETTLE_RST;
  logic [MASK_W-1:0]    set_ff_mask   = FF_MASK_RST;
  logic [UPR_W-1:0]     set_upr       = UPR_RST;
  logic [CPS_W-1:0]     set_cps       = CPS_RST;
  logic [FFMAX_W-1:0]   set_ff_max    = FF_MAX_RST;
  logic                 set_host      = 1'b0;

  // Per-axis motion state, all zero after reset.
  longint      axis_pos    [AXES];
  longint      axis_goal   [AXES];
  bit          axis_seek   [AXES];
  int unsigned axis_settle [AXES];
  longint      axis_jog    [AXES];
  longint      axis_zero   [AXES];

  in_t         move_backlog[$];
  out_t        expected_setpoints[$];
  int unsigned batch_made      = 0;
  int unsigned moves_accepted  = 0;
  int unsigned mismatch_count  = 0;
  bit          move_taken      = 1'b0;
  bit          calm_run        = 1'b0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  int unsigned hold_left       = 0;
  bit          long_hold_done  = 1'b0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  function automatic longint clamp_trk(longint v);
    if (v > TRK_HI) return TRK_HI;
    if (v < TRK_LO) return TRK_LO;
    return v;
  endfunction

  function automatic logic [31:0] clamp_word(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Velocity feedforward: step * cps * 2^20 / upr, rounded half away from zero.
  function automatic longint ff_value(int unsigned ax, longint step);
    longint unsigned mag, prod, q1, r1, q, r, upr;
    upr = set_upr;
    if (!set_ff_mask[ax] || upr == 0 || step == 0) return 0;
    mag = (step < 0) ? -step : step;
    prod = mag * set_cps;
    q1 = prod / upr;
    r1 = prod % upr;
    if (q1 >= (64'd1 << 32)) begin
      q = set_ff_max;
    end else begin
      q = (q1 << FRAC_BITS) + (r1 << FRAC_BITS) / upr;
      r = (r1 << FRAC_BITS) % upr;
      if (2 * r >= upr) q++;
      if (q > set_ff_max) q = set_ff_max;
    end
    return (step < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void halt_axis(int unsigned ax);
    axis_seek[ax]   = 1'b0;
    axis_settle[ax] = 0;
    axis_jog[ax]    = 0;
  endfunction

  function automatic void start_seek(int unsigned ax, longint target);
    axis_goal[ax]   = target;
    axis_seek[ax]   = 1'b1;
    axis_settle[ax] = 0;
    axis_jog[ax]    = 0;
  endfunction

  // Apply one request to the axis state and return the setpoint it yields.
  function automatic out_t predict_setpoint(in_t cmd);
    out_t              res;
    int unsigned       ax;
    longint            val, act, step, ff, pos, g, t;
    longint unsigned   err_mag;
    logic signed [31:0] neg_word;
    res = '0;
    if (cmd.axis >= AXES) return res;
    ax   = cmd.axis;
    val  = cmd.value;
    act  = cmd.fb_pos;
    step = 0;
    ff   = 0;
    case (op_e'(cmd.operation))
      OP_TICK: begin
        if (axis_seek[ax]) begin
          g = axis_goal[ax];
          t = axis_pos[ax];
          err_mag = (g >= t) ? g - t : t - g;
          if (err_mag < set_deadband) begin
            if (axis_settle[ax] < 255) axis_settle[ax]++;
            // The step toward the goal still applies on the tick that ends seeking.
            if (axis_settle[ax] >= set_settle) halt_axis(ax);
          end else begin
            axis_settle[ax] = 0;
          end
          if (err_mag > set_max_step) err_mag = set_max_step;
          step = (g >= t) ? longint'(err_mag) : -longint'(err_mag);
          axis_pos[ax] = t + step;
        end else if (axis_jog[ax] != 0) begin
          t = axis_pos[ax];
          axis_pos[ax] = clamp_trk(t + axis_jog[ax]);
          step = axis_pos[ax] - t;
        end
        ff = ff_value(ax, step);
      end
      OP_ABS_HOST: start_seek(ax, clamp_trk(val - axis_zero[ax]));
      OP_ABS_RAW:  start_seek(ax, clamp_trk(val));
      OP_REL: begin
        // A zero distance stops the axis.
        if (val == 0) halt_axis(ax);
        else start_seek(ax, clamp_trk(axis_pos[ax] + val));
      end
      OP_CONT: begin
        axis_seek[ax] = 1'b0;
        axis_jog[ax]  = val;
      end
      OP_STOP: halt_axis(ax);
      OP_ZERO: begin
        neg_word = -cmd.value;
        axis_zero[ax] = neg_word;
        halt_axis(ax);
      end
      default: begin
        axis_pos[ax] = clamp_trk(act);
        halt_axis(ax);
      end
    endcase
    pos = axis_pos[ax];
    if (set_host) pos = pos + axis_zero[ax];
    res.target_pos  = clamp_word(pos);
    res.vel_ffwd    = ff[31:0];
    res.motion_step = step[31:0];
    res.seeking     = axis_seek[ax];
    return res;
  endfunction

  task automatic check_setpoint(out_t got);
    out_t want;
    if (expected_setpoints.size() == 0) begin
      report_mismatch("setpoint with nothing expected", got.target_pos, '0);
      return;
    end
    want = expected_setpoints.pop_front();
    if (got.target_pos !== want.target_pos)
      report_mismatch("target_pos", got.target_pos, want.target_pos);
    if (got.vel_ffwd !== want.vel_ffwd)
      report_mismatch("vel_ffwd", got.vel_ffwd, want.vel_ffwd);
    if (got.motion_step !== want.motion_step)
      report_mismatch("motion_step", got.motion_step, want.motion_step);
    if (got.seeking !== want.seeking)
      report_mismatch("seeking", 32'(got.seeking), 32'(want.seeking));
  endtask

  // Monitor: check the returned setpoint, then predict the accepted request.
  always @(posedge clk_i) begin
    move_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_setpoint(out_o);
      if (in_valid_i && !in_stall_o) begin
        expected_setpoints.push_back(predict_setpoint(in_i));
        moves_accepted <= moves_accepted + 1;
      end
    end
  end

  // Driver: hold the request until taken, then advance or idle for a burst.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || move_taken)) begin
      if (send_gap != 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!calm_run && $urandom_range(0, 11) == 0) begin
        send_gap   <= $urandom_range(1, 16) - 1;
        in_valid_i <= 1'b0;
      end else if (move_backlog.size() != 0) begin
        in_i       <= move_backlog.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold that backs up the block.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!long_hold_done && moves_accepted >= LONG_HOLD_AT) begin
      hold_left      <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
      out_stall_i    <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm_run && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(1, 16) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void queue_move(int unsigned ax, op_e op, logic [31:0] val,
                                     logic [31:0] act);
    in_t cmd;
    cmd.axis       = ax[2:0];
    cmd.operation  = op;
    cmd.value      = val;
    cmd.fb_pos     = act;
    move_backlog.push_back(cmd);
    if (ax < AXES) batch_made++;
  endfunction

  // Mostly values near zero, sometimes full range or the word extremes.
  function automatic logic [31:0] pick_value(int unsigned span);
    case ($urandom_range(0, 15))
      0:       return $urandom;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'hffff_ffff;
      4:       return 32'h0000_0000;
      default: return 32'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic logic [31:0] with_junk(logic [31:0] val, int unsigned w);
    return (32'($urandom) << w) | val;
  endfunction

  // Ticks mostly on one axis, some interleaved on others.
  function automatic void tick_run(int unsigned ax, int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_move($urandom_range(0, AXES - 1), OP_TICK, $urandom, $urandom);
      end else begin
        queue_move(ax, OP_TICK, $urandom, $urandom);
      end
    end
  endfunction

  // Drive one axis into the tracker limit with a full-size continuous jog.
  function automatic void runaway(int unsigned ax, logic [31:0] edge_word);
    queue_move(ax, OP_RESYNC, $urandom, edge_word);
    queue_move(ax, OP_CONT, edge_word, $urandom);
    for (int unsigned k = 0; k < RUNAWAY_TICKS; k++) queue_move(ax, OP_TICK, $urandom, $urandom);
    queue_move(ax, OP_REL, edge_word, $urandom);
    queue_move(ax, OP_TICK, $urandom, $urandom);
    queue_move(ax, OP_TICK, $urandom, $urandom);
  endfunction

  function automatic void plan_batch(int unsigned count, int unsigned span);
    int unsigned ax, n;
    batch_made = 0;
    while (batch_made < count) begin
      ax = $urandom_range(0, AXES - 1);
      n  = $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          queue_move(ax, op_e'($urandom_range(OP_ABS_HOST, OP_REL)), pick_value(span),
                     $urandom);
          tick_run(ax, n);
        end
        4, 5: begin
          queue_move(ax, OP_CONT, pick_value(span / 8), $urandom);
          tick_run(ax, n / 2 + 1);
          if ($urandom_range(0, 1) == 0) queue_move(ax, OP_STOP, $urandom, $urandom);
        end
        6: begin
          queue_move(ax, OP_ZERO, pick_value(span), $urandom);
          queue_move(ax, OP_RESYNC, $urandom, pick_value(span));
          tick_run(ax, n / 4 + 1);
        end
        7: begin
          queue_move(ax, OP_STOP, $urandom, $urandom);
          tick_run(ax, 2);
        end
        8: begin
          // Noise: any axis, any operation, any field content.
          repeat ($urandom_range(1, 4)) begin
            queue_move($urandom_range(0, 7), op_e'($urandom_range(OP_TICK, OP_RESYNC)),
                       $urandom, $urandom);
          end
        end
        default: tick_run(ax, n / 4 + 1);
      endcase
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAX_STEP:    set_max_step = data[MAXSTEP_W-1:0];
      CFG_DEADBAND:    set_deadband = data[DB_W-1:0];
      CFG_SETTLE:      set_settle   = data[SETTLE_W-1:0];
      CFG_FF_MASK:     set_ff_mask  = data[MASK_W-1:0];
      CFG_UPR:         set_upr      = data[UPR_W-1:0];
      CFG_CPS:         set_cps      = data[CPS_W-1:0];
      CFG_FF_MAX:      set_ff_max   = data[FFMAX_W-1:0];
      CFG_HOST_COORDS: set_host     = data[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [31:0] mstep, logic [31:0] db, logic [31:0] settle,
                               logic [31:0] mask, logic [31:0] upr, logic [31:0] cps,
                               logic [31:0] ffmax, logic [31:0] host);
    write_reg(CFG_MAX_STEP, mstep);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_FF_MASK, mask);
    write_reg(CFG_UPR, upr);
    write_reg(CFG_CPS, cps);
    write_reg(CFG_FF_MAX, ffmax);
    write_reg(CFG_HOST_COORDS, host);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pause: wait until every request is out and every setpoint is back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (move_backlog.size() != 0 || in_valid_i || expected_setpoints.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    for (int unsigned a = 0; a < AXES; a++) begin
      axis_pos[a]    = 0;
      axis_goal[a]   = 0;
      axis_seek[a]   = 1'b0;
      axis_settle[a] = 0;
      axis_jog[a]    = 0;
      axis_zero[a]   = 0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass on reset settings: seek and settle, word-size jogs,
    // soft zero wrap, zero-distance relative, resync at the word extremes,
    // axes out of range.
    queue_move(0, OP_ABS_RAW, 32'd12000, $urandom);
    for (int unsigned k = 0; k < 6; k++) queue_move(0, OP_TICK, 32'd0, 32'd0);
    queue_move(1, OP_CONT, 32'h7fff_ffff, 32'd0);
    queue_move(1, OP_TICK, 32'd0, 32'd0);
    queue_move(1, OP_CONT, 32'h8000_0000, 32'd0);
    queue_move(1, OP_TICK, 32'd0, 32'd0);
    queue_move(2, OP_ZERO, 32'h8000_0000, 32'd0);
    queue_move(2, OP_ABS_HOST, 32'd100, 32'd0);
    queue_move(2, OP_REL, 32'd0, 32'd0);
    queue_move(2, OP_REL, 32'hffff_fff9, 32'd0);
    queue_move(2, OP_STOP, 32'd0, 32'd0);
    queue_move(3, OP_RESYNC, 32'd0, 32'h7fff_ffff);
    queue_move(3, OP_CONT, 32'h7fff_ffff, 32'd0);
    queue_move(3, OP_TICK, 32'd0, 32'd0);
    queue_move(5, OP_TICK, 32'hffff_ffff, 32'hffff_ffff);
    queue_move(7, OP_RESYNC, $urandom, $urandom);
    queue_move(4, OP_RESYNC, 32'd0, 32'h8000_0000);
    queue_move(4, OP_CONT, 32'hffff_ffff, 32'd0);
    queue_move(4, OP_TICK, 32'd0, 32'd0);
    wait_drained();

    // Mid-range settings in host coordinates.
    load_settings($urandom_range(1000, 3000), $urandom_range(1, 50), $urandom_range(1, 5),
                  $urandom_range(0, 31), $urandom_range(1000, 100000),
                  $urandom_range(250, 8000), $urandom_range(1000, 32'h7fff_ffff), 1);
    @(posedge clk_i);
    plan_batch(300, 20000);
    wait_drained();

    // Upper extremes; one revolution per unit makes the feedforward saturate.
    load_settings(32'h7fff_ffff, 32'h0000_ffff, 32'h0000_00ff, 32'h1f, 32'd1,
                  32'h0001_ffff, 32'h7fff_ffff, 1);
    @(posedge clk_i);
    runaway($urandom_range(0, AXES - 1), 32'h7fff_ffff);
    plan_batch(150, 1000000);
    wait_drained();

    // Lower extremes: no step while seeking, never in position, feedforward off.
    load_settings(32'd0, 32'd0, 32'd0, 32'h1f, 32'd0, 32'd1, 32'd0, 0);
    @(posedge clk_i);
    runaway($urandom_range(0, AXES - 1), 32'h8000_0000);
    plan_batch(150, 50000);
    wait_drained();

    // Random settings with junk above each register width; zero settle allowed.
    load_settings(with_junk($urandom_range(1, 5000), MAXSTEP_W),
                  with_junk($urandom_range(1, 200), DB_W),
                  with_junk($urandom_range(0, 4), SETTLE_W),
                  with_junk($urandom_range(0, 31), MASK_W),
                  with_junk($urandom_range(1, 32'h7fff_ffff), UPR_W),
                  with_junk($urandom_range(1, 100000), CPS_W),
                  with_junk($urandom & 32'h7fff_ffff, FFMAX_W),
                  with_junk($urandom_range(0, 1), 1));
    @(posedge clk_i);
    plan_batch(250, 100000);
    wait_drained();

    // Last stretch on reset values with no idling on either side.
    calm_run = 1'b1;
    load_settings(32'(MAX_STEP_RST), 32'(DEADBAND_RST), 32'(SETTLE_RST), 32'(FF_MASK_RST),
                  32'(UPR_RST), 32'(CPS_RST), 32'(FF_MAX_RST), 0);
    @(posedge clk_i);
    plan_batch(200, 20000);
    wait_drained();

    if (expected_setpoints.size() != 0)
      report_mismatch("setpoints never returned", expected_setpoints.size(), '0);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
